/* sv/dhte_pkg.sv */
// shared types and constants of the double hash table engine
package dhte_pkg;

  // table geometry
  localparam int TABLE_SIZE = 13;
  localparam int IDX_W      = $clog2(TABLE_SIZE);

  // record and result field widths
  localparam int KEY_W    = 31;
  localparam int AGE_W    = 8;
  localparam int SAL_W    = 32;
  localparam int SLOT_W   = 4;
  localparam int STATUS_W = 3;
  localparam int ENTRY_W  = KEY_W + AGE_W + SAL_W;

  // stream packing
  localparam int IN_DATA_W  = ((ENTRY_W + 7) / 8) * 8;
  localparam int OUT_BITS   = SLOT_W + AGE_W + SAL_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // remainder units: quotient by reciprocal multiply, ceil(2^s / d), exact for any key
  localparam int HASH_STEPS  = 1;
  localparam int HCNT_W      = $clog2(HASH_STEPS + 1);
  localparam int RCP_W       = KEY_W + 1;
  localparam int RCP_SHIFT_N = KEY_W + $clog2(TABLE_SIZE);
  localparam int RCP_SHIFT_M = KEY_W + $clog2(TABLE_SIZE - 1);
  localparam logic [RCP_W-1:0] RCP_N =
    RCP_W'(((64'd1 << RCP_SHIFT_N) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE));
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_SHIFT_M) + 64'(TABLE_SIZE - 2)) / 64'(TABLE_SIZE - 1));
  localparam logic [IDX_W-1:0] N_LOW = IDX_W'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] M_LOW = IDX_W'(TABLE_SIZE - 1);

  localparam logic [IDX_W:0]    TBL_N      = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0]  LAST_PROBE = IDX_W'(TABLE_SIZE - 1);
  localparam logic [HCNT_W-1:0] HASH_LAST  = HCNT_W'(HASH_STEPS);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    load;
    logic    hash_step;
    logic    probe_init;
    logic    advance;
    logic    write;
    logic    emit;
    status_e status;
  } dhte_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic hash_done;
    logic slot_valid;
    logic key_match;
    logic last_probe;
    logic out_busy;
  } dhte_sts_t;

endpackage

/* sv/dhte_ram.sv */
// generic single write port, single read port ram with registered read
module dhte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/dhte_ctrl.sv */
// controller state machine: hashing, probe walk and result hand-off
module dhte_ctrl import dhte_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  dhte_sts_t sts_i,
  output dhte_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_CHECK,
    S_FINISH
  } state_e;

  state_e  state_q, state_d;
  status_e res_q, res_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '{status: res_q, default: 1'b0};
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (sts_i.hash_done) begin
          cmd_o.probe_init = 1'b1;
          state_d          = S_PROBE;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      S_PROBE: begin
        if (!sts_i.slot_valid) begin
          // free slot ends the walk
          if (sts_i.op == OP_INSERT) begin
            cmd_o.write = 1'b1;
            res_d       = ST_INSERTED;
          end else begin
            res_d = ST_NOT_FOUND;
          end
          state_d = S_FINISH;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.key_match) begin
          res_d   = (sts_i.op == OP_INSERT) ? ST_DUPLICATE : ST_FOUND;
          state_d = S_FINISH;
        end else if (sts_i.last_probe) begin
          res_d   = (sts_i.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
          state_d = S_FINISH;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_PROBE;
        end
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign s_tready_o = (state_q == S_IDLE);

  // state and result code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_INSERTED;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // a result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> !sts_i.out_busy)
    else $error("result emitted over a pending result");

  // only inserts write the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write |-> sts_i.op == OP_INSERT)
    else $error("table written by a lookup");

  // the walk never steps past the last probe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.advance |-> !sts_i.last_probe)
    else $error("probe walk ran past the table size");

endmodule

/* sv/dhte_dp.sv */
// datapath: input capture, remainder units, probe index, slot store and result register
module dhte_dp import dhte_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dhte_cmd_t           cmd_i,
  output dhte_sts_t           sts_o,
  input  op_e                 in_op_i,
  input  logic [KEY_W-1:0]    in_key_i,
  input  logic [AGE_W-1:0]    in_age_i,
  input  logic [SAL_W-1:0]    in_sal_i,
  input  logic                m_tready_i,
  output logic                out_valid_o,
  output status_e             out_status_o,
  output logic [SLOT_W-1:0]   out_slot_o,
  output logic [AGE_W-1:0]    out_age_o,
  output logic [SAL_W-1:0]    out_sal_o
);

  // captured item
  op_e              op_q;
  logic [KEY_W-1:0] key_q;
  logic [AGE_W-1:0] age_q;
  logic [SAL_W-1:0] sal_q;

  // remainder units
  logic [HCNT_W-1:0]        hcnt_q;
  logic [KEY_W+RCP_W-1:0]   prod_n, prod_m;
  logic [IDX_W-1:0]         qn_q, qm_q;
  logic [IDX_W-1:0]         r1, r2;

  // probe walk
  logic [IDX_W-1:0] idx_q, step_q, cnt_q;
  logic [IDX_W:0]   sum;
  logic [IDX_W-1:0] idx_next;

  // slot store
  logic [TABLE_SIZE-1:0] valid_q;
  logic [ENTRY_W-1:0]    rdata;
  logic [KEY_W-1:0]      rd_key;
  logic [AGE_W-1:0]      rd_age;
  logic [SAL_W-1:0]      rd_sal;

  // result register
  logic              out_valid_q;
  status_e           out_status_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [AGE_W-1:0]  out_age_q;
  logic [SAL_W-1:0]  out_sal_q;

  // quotients of key / N and key / (N-1) by reciprocal multiply
  assign prod_n = {{RCP_W{1'b0}}, key_q} * {{KEY_W{1'b0}}, RCP_N};
  assign prod_m = {{RCP_W{1'b0}}, key_q} * {{KEY_W{1'b0}}, RCP_M};

  // remainders fit in IDX_W bits, so only the low quotient bits are needed
  assign r1 = key_q[IDX_W-1:0] - qn_q * N_LOW;
  assign r2 = key_q[IDX_W-1:0] - qm_q * M_LOW;

  // capture item and keep the low quotient bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_op_i;
      key_q <= in_key_i;
      age_q <= in_age_i;
      sal_q <= in_sal_i;
    end else if (cmd_i.hash_step) begin
      qn_q <= prod_n[RCP_SHIFT_N +: IDX_W];
      qm_q <= prod_m[RCP_SHIFT_M +: IDX_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= '0;
    end else if (cmd_i.load) begin
      hcnt_q <= '0;
    end else if (cmd_i.hash_step) begin
      hcnt_q <= hcnt_q + 1'b1;
    end
  end

  // next probe: (idx + step) mod N, both below N
  always_comb begin
    sum = {1'b0, idx_q} + {1'b0, step_q};
    if (sum >= TBL_N) begin
      sum = sum - TBL_N;
    end
    idx_next = sum[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      step_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.probe_init) begin
      idx_q  <= r1;
      step_q <= r2 + 1'b1;
      cnt_q  <= '0;
    end else if (cmd_i.advance) begin
      idx_q <= idx_next;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // valid marks, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.write) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  // record store, read continuously at the current probe
  dhte_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (idx_q),
    .wdata_i ({sal_q, age_q, key_q}),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign rd_key = rdata[KEY_W-1:0];
  assign rd_age = rdata[KEY_W +: AGE_W];
  assign rd_sal = rdata[KEY_W+AGE_W +: SAL_W];

  // status to the controller
  assign sts_o.op         = op_q;
  assign sts_o.hash_done  = (hcnt_q == HASH_LAST);
  assign sts_o.slot_valid = valid_q[idx_q];
  assign sts_o.key_match  = (rd_key == key_q);
  assign sts_o.last_probe = (cnt_q == LAST_PROBE);
  assign sts_o.out_busy   = out_valid_q & ~m_tready_i;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.status;
      out_slot_q   <= (cmd_i.status inside {ST_INSERTED, ST_FOUND}) ? SLOT_W'(idx_q) : '0;
      out_age_q    <= (cmd_i.status == ST_FOUND) ? rd_age : '0;
      out_sal_q    <= (cmd_i.status == ST_FOUND) ? rd_sal : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_slot_o   = out_slot_q;
  assign out_age_o    = out_age_q;
  assign out_sal_o    = out_sal_q;

  // an insert only ever fills a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write |-> !valid_q[idx_q])
    else $error("insert into an occupied slot");

  // the probe index stays inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < TBL_N)
    else $error("probe index out of range");

  // a found record comes from a valid slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.status == ST_FOUND) |-> valid_q[idx_q])
    else $error("found result from an empty slot");

endmodule

/* sv/double_hash_table_engine.sv */
// top level of the double hash table engine: stream ports, controller and datapath
//
// channel   dir   tdata (lsb first)                     tuser
// s_axis    in    key[30:0], age[38:31], salary[70:39]  operation (0 insert, 1 lookup)
// m_axis    out   slot[3:0], age[11:4], salary[43:12]   status[2:0]
//
// an item goes from acceptance through the reciprocal multiplies, then forming both hashes,
// then per probe a slot state and a check state for the registered read of the record store,
// with no check state when the walk ends on a free slot, for 1 to TABLE_SIZE probes, then
// issue of the result, which waits while the previous result is still held
// reset empties the table at once through per-slot valid marks, no clearing pass
// the next item is taken while a result waits; it stalls only at its own result
module double_hash_table_engine import dhte_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // key, age, salary_bits, zero pad
  input  logic                  s_axis_tuser_i,   // operation
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // slot, found_age, found_salary_bits, pad
  output logic [STATUS_W-1:0]   m_axis_tuser_o    // status
);

  dhte_cmd_t         cmd;
  dhte_sts_t         sts;
  status_e           out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [AGE_W-1:0]  out_age;
  logic [SAL_W-1:0]  out_sal;

  // sequencing
  dhte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table and arithmetic
  dhte_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (op_e'(s_axis_tuser_i)),
    .in_key_i     (s_axis_tdata_i[KEY_W-1:0]),
    .in_age_i     (s_axis_tdata_i[KEY_W +: AGE_W]),
    .in_sal_i     (s_axis_tdata_i[KEY_W+AGE_W +: SAL_W]),
    .m_tready_i   (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_status_o (out_status),
    .out_slot_o   (out_slot),
    .out_age_o    (out_age),
    .out_sal_o    (out_sal)
  );

  // result packing
  assign m_axis_tdata_o = OUT_DATA_W'({out_sal, out_age, out_slot});
  assign m_axis_tuser_o = out_status;

endmodule

/* tb/dhte_checker.sv */
// checker of the double hash table engine: table predictor and in-order result scoreboard
module dhte_checker import dhte_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // key, age, salary_bits, zero pad
  input  logic                  s_axis_tuser_i,   // operation
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,   // slot, found_age, found_salary_bits, pad
  input  logic [STATUS_W-1:0]   m_axis_tuser_i,   // status
  output int                    mismatches_o,
  output int                    pending_o
);

  typedef struct {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [AGE_W-1:0]   age;
    logic [SAL_W-1:0]   salary;
  } table_answer_t;

  // predicted copy of the record store
  bit               rec_valid  [TABLE_SIZE];
  logic [KEY_W-1:0] rec_key    [TABLE_SIZE];
  logic [AGE_W-1:0] rec_age    [TABLE_SIZE];
  logic [SAL_W-1:0] rec_salary [TABLE_SIZE];

  table_answer_t answer_q [$];
  table_answer_t expected;
  table_answer_t actual;

  // walk the double hash probe sequence and apply one item to the predicted table
  function automatic table_answer_t apply_item(input op_e op, input logic [KEY_W-1:0] key,
                                               input logic [AGE_W-1:0] age,
                                               input logic [SAL_W-1:0] salary);
    table_answer_t ans;
    int unsigned   k;
    int unsigned   idx;
    int unsigned   stride;
    k      = key;
    idx    = k % TABLE_SIZE;
    stride = (1 + k % (TABLE_SIZE - 1)) % TABLE_SIZE;
    ans.slot   = '0;
    ans.age    = '0;
    ans.salary = '0;
    // every probe hit another key: full on insert, miss on lookup
    if (op == OP_INSERT) begin
      ans.status = ST_FULL;
    end else begin
      ans.status = ST_NOT_FOUND;
    end
    for (int j = 0; j < TABLE_SIZE; j++) begin
      if (!rec_valid[idx]) begin
        if (op == OP_INSERT) begin
          rec_valid[idx]  = 1'b1;
          rec_key[idx]    = key;
          rec_age[idx]    = age;
          rec_salary[idx] = salary;
          ans.status      = ST_INSERTED;
          ans.slot        = SLOT_W'(idx);
        end else begin
          ans.status = ST_NOT_FOUND;
        end
        return ans;
      end
      if (rec_key[idx] == key) begin
        if (op == OP_INSERT) begin
          ans.status = ST_DUPLICATE;
        end else begin
          ans.status = ST_FOUND;
          ans.slot   = SLOT_W'(idx);
          ans.age    = rec_age[idx];
          ans.salary = rec_salary[idx];
        end
        return ans;
      end
      idx = (idx + stride) % TABLE_SIZE;
    end
    return ans;
  endfunction

  // predict on accepted input items, compare accepted result items in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
        rec_valid[i] = 1'b0;
      end
      answer_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        answer_q.push_back(apply_item(op_e'(s_axis_tuser_i),
                                      s_axis_tdata_i[KEY_W-1:0],
                                      s_axis_tdata_i[KEY_W +: AGE_W],
                                      s_axis_tdata_i[KEY_W+AGE_W +: SAL_W]));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        actual.status = status_e'(m_axis_tuser_i);
        actual.slot   = m_axis_tdata_i[SLOT_W-1:0];
        actual.age    = m_axis_tdata_i[SLOT_W +: AGE_W];
        actual.salary = m_axis_tdata_i[SLOT_W+AGE_W +: SAL_W];
        if (answer_q.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("unexpected result: status %0d slot %0d age %0d salary %h",
                     m_axis_tuser_i, actual.slot, actual.age, actual.salary);
          end
          mismatches_o = mismatches_o + 1;
        end else begin
          expected = answer_q.pop_front();
          if (actual.status !== expected.status || actual.slot !== expected.slot ||
              actual.age !== expected.age || actual.salary !== expected.salary) begin
            if (mismatches_o < 10) begin
              $display("result mismatch: expected status %0d slot %0d age %0d salary %h",
                       expected.status, expected.slot, expected.age, expected.salary);
              $display("                 actual   status %0d slot %0d age %0d salary %h",
                       m_axis_tuser_i, actual.slot, actual.age, actual.salary);
            end
            mismatches_o = mismatches_o + 1;
          end
        end
      end
      pending_o = answer_q.size();
    end
  end

endmodule

/* tb/double_hash_table_engine_tb.sv */
// stimulus, idling and verdict for the double hash table engine
module double_hash_table_engine_tb;
  import dhte_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 60;
  // keys spaced by TABLE_SIZE share h1, which builds long probe chains
  localparam int unsigned CHAIN_SPAN = 165191048;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]   m_axis_tuser_o;

  int mismatches;
  int pending;
  int idle_phase;
  int items_sent;
  bit held_off;
  int hold_left;

  logic [KEY_W-1:0] known_keys [$];

  double_hash_table_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  dhte_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #8000000;
    $display("double_hash_table_engine test failed");
    $finish;
  end

  // offer one item at a falling edge and hold it until accepted
  task automatic send_item(input op_e op, input logic [KEY_W-1:0] key,
                           input logic [AGE_W-1:0] age, input logic [SAL_W-1:0] salary);
    int idle_pct;
    idle_pct = (idle_phase == 1) ? 47 : (idle_phase == 3) ? 35 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = '0;
    s_axis_tdata_i[KEY_W-1:0]            = key;
    s_axis_tdata_i[KEY_W +: AGE_W]       = age;
    s_axis_tdata_i[KEY_W+AGE_W +: SAL_W] = salary;
    if (op == OP_INSERT) begin
      known_keys.push_back(key);
    end
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    items_sent = items_sent + 1;
    @(negedge clk_i);
  endtask

  // receiver: random stalls per phase, plus one long hold-off early in the run
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!held_off && items_sent >= 60) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left       = hold_left - 1;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = ($urandom_range(0, 99) >=
                           ((idle_phase == 2) ? 47 : (idle_phase == 3) ? 35 : 0));
      end
    end
  end

  // reset, directed items, random items, drain and verdict
  initial begin
    logic [KEY_W-1:0] key;
    op_e              op;
    int               roll;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_INSERT;
    m_axis_tready_i = 1'b0;
    idle_phase      = 0;
    items_sent      = 0;
    held_off        = 1'b0;
    hold_left       = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty table miss, extreme keys and payloads
    send_item(OP_LOOKUP, '0, '0, '0);
    send_item(OP_INSERT, '0, '0, '0);
    send_item(OP_INSERT, {KEY_W{1'b1}}, {AGE_W{1'b1}}, {SAL_W{1'b1}});
    send_item(OP_LOOKUP, '0, {AGE_W{1'b1}}, {SAL_W{1'b1}});
    send_item(OP_LOOKUP, {KEY_W{1'b1}}, '0, '0);
    // duplicate insert leaves the stored payload alone
    send_item(OP_INSERT, '0, 8'h5a, 32'hdead_beef);
    send_item(OP_LOOKUP, '0, '0, '0);
    // keys with equal h1 walk the probe sequence
    send_item(OP_INSERT, KEY_W'(13), 8'h11, 32'h1111_1111);
    send_item(OP_INSERT, KEY_W'(156), 8'h22, 32'h2222_2222);
    send_item(OP_INSERT, KEY_W'(26), 8'h33, 32'h3333_3333);
    send_item(OP_LOOKUP, KEY_W'(156), '0, '0);
    send_item(OP_LOOKUP, KEY_W'(26), '0, '0);
    send_item(OP_LOOKUP, KEY_W'(39), '0, '0);
    send_item(OP_INSERT, KEY_W'(13), 8'h44, 32'h4444_4444);
    send_item(OP_LOOKUP, KEY_W'(13), '0, '0);

    // random items: the table fills early, later items hit full and exhausted walks
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_phase = (i * 4) / RANDOM_ITEMS;
      op   = ($urandom_range(0, 99) < 50) ? OP_INSERT : OP_LOOKUP;
      roll = $urandom_range(0, 99);
      if (known_keys.size() != 0 && roll < 45) begin
        key = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (roll < 75) begin
        key = KEY_W'($urandom());
      end else begin
        key = KEY_W'($urandom_range(0, CHAIN_SPAN) * TABLE_SIZE + $urandom_range(0, 2) * 5);
      end
      send_item(op, key, AGE_W'($urandom()), $urandom());
    end
    s_axis_tvalid_i = 1'b0;

    // drain every outstanding result, then watch for stray ones
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("double_hash_table_engine test passed");
    end else begin
      $display("double_hash_table_engine test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/dhte_pkg.sv
sv/dhte_ram.sv
sv/dhte_ctrl.sv
sv/dhte_dp.sv
sv/double_hash_table_engine.sv
tb/dhte_checker.sv
tb/double_hash_table_engine_tb.sv
